// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition must hold on every clock outside reset
`define IDS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// consequence must hold on the clock after the trigger
`define IDS_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define IDS_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define IDS_ASSERT_NEXT(label, clk, rst, trig, cons, msg)
`endif
`endif

// ===== hw/rtl/ids_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ids_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MIN_DIM    = 3;
   localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
   localparam int DIM_BITS   = 11;
   localparam int PIX_BITS   = 16;
   localparam int GAIN_BITS  = 15;
   localparam int GAIN_FRAC  = 16;
   localparam int LAP_BITS   = 19;
   localparam int PROD_BITS  = 35;
   localparam int RES_BITS   = 20;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIFFUSION_GAIN = 2'd2;
   localparam int CSR_DATA_BITS = 15;

   localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = 11'd1024;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET   = 15'd13107;

   // input op codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // result queue
   localparam int OUTQ_DEPTH    = 8;
   localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_BITS = OUTQ_PTR_BITS + 1;

   typedef logic [PIX_BITS-1:0]  pix_type;
   typedef logic [ADDR_BITS-1:0] addr_type;

   // line buffer access for one beat
   typedef struct packed {
      logic     wr_en;
      logic     rd_en;
      addr_type wr_addr;
      addr_type rd_addr;
      pix_type  above_wdata;
      pix_type  centre_wdata;
   } lbuf_cmd_type;

   // neighbourhood of one output pixel, right neighbour follows in the next cycle
   typedef struct packed {
      pix_type u;
      pix_type up;
      pix_type lf;
      pix_type dn;
      logic    bypass;
      logic    last;
   } stencil_type;

   typedef struct packed {
      pix_type pixel;
      logic    last;
   } result_type;

   typedef struct packed {
      logic v1;
      logic v2;
      logic v3;
   } pipe_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ids_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ids_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic [ids_pkg::PIX_BITS-1:0]        pixel_in;

   modport source (output valid, output op, output pixel_in, input ready);
   modport sink   (input valid, input op, input pixel_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ids_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ids_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ids_pkg::PIX_BITS-1:0]        pixel_out;
   logic                                frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/isotropic_diffusion_stencil.sv =====
// the result for pixel (r-1, c) is offered once pixel (r, c) is accepted, through the
// pipe stages and result queue; flush beats release the last row, one pixel per beat
// throughput: one beat per cycle, set by the single read and write of each line memory
// and by credit on the 8-entry result queue
// reset: registers to defaults, counters and queue cleared, line memories keep contents
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module isotropic_diffusion_stencil (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ids_req_if.sink                                   req_ch,
   ids_rsp_if.source                                 rsp_ch,
   input  wire logic                                 csr_wr_en,
   input  wire logic [ids_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [ids_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // configuration registers
   logic [ids_pkg::DIM_BITS-1:0]  width_ff, width_in;
   logic [ids_pkg::DIM_BITS-1:0]  height_ff, height_in;
   logic [ids_pkg::GAIN_BITS-1:0] gain_ff, gain_in;

   // frame position and the left neighbour of the window
   ids_pkg::addr_type             col_ff, col_in;
   ids_pkg::addr_type             row_ff, row_in;
   logic                          full_ff, full_in;
   ids_pkg::pix_type              lf_ff, lf_in;

   logic [ids_pkg::DIM_BITS-1:0]  eff_w, eff_h;
   logic [ids_pkg::DIM_BITS-1:0]  col_p1, row_p1;
   logic                          col_last, row_last;
   ids_pkg::addr_type             next_col;
   logic                          border;

   logic                          fire, pix_go, flush_go;
   ids_pkg::lbuf_cmd_type         lbuf_cmd;
   ids_pkg::pix_type              above_rd, centre_rd;

   logic                          stage_valid;
   ids_pkg::stencil_type          stage_data;
   logic                          q_push;
   ids_pkg::result_type           q_data;
   ids_pkg::pipe_status_type      pstat;
   logic [ids_pkg::OUTQ_CNT_BITS-1:0] q_count;
   logic [ids_pkg::OUTQ_CNT_BITS:0]   occupancy;

   // register writes, unknown indexes are dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      gain_in   = gain_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ids_pkg::CSR_FRAME_WIDTH: begin
               width_in = csr_wdata[ids_pkg::DIM_BITS-1:0];
            end
            ids_pkg::CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata[ids_pkg::DIM_BITS-1:0];
            end
            ids_pkg::CSR_DIFFUSION_GAIN: begin
               gain_in = csr_wdata;
            end
            default: begin
               gain_in = gain_ff;
            end
         endcase
      end
   end

   // frame size clamped to the supported range
   always_comb begin
      if (width_ff < ids_pkg::DIM_BITS'(ids_pkg::MIN_DIM)) begin
         eff_w = ids_pkg::DIM_BITS'(ids_pkg::MIN_DIM);
      end else if (width_ff > ids_pkg::DIM_BITS'(ids_pkg::MAX_WIDTH)) begin
         eff_w = ids_pkg::DIM_BITS'(ids_pkg::MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff < ids_pkg::DIM_BITS'(ids_pkg::MIN_DIM)) begin
         eff_h = ids_pkg::DIM_BITS'(ids_pkg::MIN_DIM);
      end else if (height_ff > ids_pkg::DIM_BITS'(ids_pkg::MAX_HEIGHT)) begin
         eff_h = ids_pkg::DIM_BITS'(ids_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   // accept while the queue has room for everything in flight
   assign occupancy = {1'b0, q_count}
                      + (ids_pkg::OUTQ_CNT_BITS + 1)'(pstat.v1)
                      + (ids_pkg::OUTQ_CNT_BITS + 1)'(pstat.v2)
                      + (ids_pkg::OUTQ_CNT_BITS + 1)'(pstat.v3);
   assign req_ch.ready = (occupancy < (ids_pkg::OUTQ_CNT_BITS + 1)'(ids_pkg::OUTQ_DEPTH));

   assign fire     = req_ch.valid && req_ch.ready;
   // pixels during drain and flushes outside drain are dropped
   assign pix_go   = fire && (req_ch.op == ids_pkg::OP_PIXEL) && !full_ff;
   assign flush_go = fire && (req_ch.op == ids_pkg::OP_FLUSH) && full_ff;

   // row and column position; a shrunk size ends the row or frame at once
   assign col_p1   = {1'b0, col_ff} + 1'b1;
   assign row_p1   = {1'b0, row_ff} + 1'b1;
   assign col_last = (col_p1 >= eff_w);
   assign row_last = (row_p1 >= eff_h);
   assign next_col = col_last ? '0 : col_p1[ids_pkg::ADDR_BITS-1:0];
   assign border   = (row_ff == ids_pkg::ADDR_BITS'(1)) || ({1'b0, row_ff} >= eff_h)
                     || (col_ff == '0) || col_last;

   // write the current column, read ahead the next one; the two never collide
   // since a row holds at least three pixels
   always_comb begin
      lbuf_cmd.wr_en        = pix_go;
      lbuf_cmd.rd_en        = pix_go || flush_go;
      lbuf_cmd.wr_addr      = col_ff;
      lbuf_cmd.rd_addr      = next_col;
      lbuf_cmd.above_wdata  = centre_rd;
      lbuf_cmd.centre_wdata = req_ch.pixel_in;
   end

   ids_lbuf u_lbuf (
      .clock     (clock),
      .cmd       (lbuf_cmd),
      .above_rd  (above_rd),
      .centre_rd (centre_rd)
   );

   // a pixel beat below the first row releases the pixel above it,
   // a flush beat releases one pixel of the last row unchanged
   always_comb begin
      stage_valid       = (pix_go && (row_ff != '0)) || flush_go;
      stage_data.u      = centre_rd;
      stage_data.up     = above_rd;
      stage_data.lf     = lf_ff;
      stage_data.dn     = req_ch.pixel_in;
      stage_data.bypass = flush_go || border;
      stage_data.last   = flush_go && col_last;
   end

   ids_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_data   (stage_data),
      .rt        (centre_rd),
      .gain      (gain_ff),
      .out_valid (q_push),
      .out_data  (q_data),
      .status    (pstat)
   );

   ids_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .count     (q_count),
      .rsp_ch    (rsp_ch)
   );

   // position update
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      full_in = full_ff;
      lf_in   = lf_ff;
      if (pix_go) begin
         lf_in  = centre_rd;
         col_in = next_col;
         if (col_last) begin
            if (row_last) begin
               full_in = 1'b1;
            end else begin
               row_in = row_p1[ids_pkg::ADDR_BITS-1:0];
            end
         end
      end else if (flush_go) begin
         col_in = next_col;
         if (col_last) begin
            // frame done, next pixel starts a new frame
            row_in  = '0;
            full_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ids_pkg::WIDTH_RESET;
         height_ff <= ids_pkg::HEIGHT_RESET;
         gain_ff   <= ids_pkg::GAIN_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         full_ff   <= 1'b0;
         lf_ff     <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         gain_ff   <= gain_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         full_ff   <= full_in;
         lf_ff     <= lf_in;
      end
   end

   // credit check keeps the queue from ever taking a beat while full
   `IDS_ASSERT_ALWAYS(a_outq_no_overflow, clock, reset, !(q_push && (q_count == ids_pkg::OUTQ_CNT_BITS'(ids_pkg::OUTQ_DEPTH))), "result queue overflow")
   // a flush during drain always starts a result
   `IDS_ASSERT_NEXT(a_flush_result, clock, reset, flush_go, pstat.v1, "flush beat lost its result")
   // the final flush returns the position to the frame start
   `IDS_ASSERT_NEXT(a_frame_restart, clock, reset, flush_go && col_last, !full_ff && (col_ff == '0) && (row_ff == '0), "frame end did not clear position")

endmodule
`default_nettype wire

// ===== hw/rtl/ids_lbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// two row memories, one write and one registered read each per cycle
module ids_lbuf (
   input  wire logic                  clock,
   input  wire ids_pkg::lbuf_cmd_type cmd,
   output ids_pkg::pix_type           above_rd,
   output ids_pkg::pix_type           centre_rd
);

   ids_pkg::pix_type above_mem_ff  [ids_pkg::MAX_WIDTH];
   ids_pkg::pix_type centre_mem_ff [ids_pkg::MAX_WIDTH];
   ids_pkg::pix_type above_rd_ff;
   ids_pkg::pix_type centre_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         above_mem_ff[cmd.wr_addr]  <= cmd.above_wdata;
         centre_mem_ff[cmd.wr_addr] <= cmd.centre_wdata;
      end
      if (cmd.rd_en) begin
         above_rd_ff  <= above_mem_ff[cmd.rd_addr];
         centre_rd_ff <= centre_mem_ff[cmd.rd_addr];
      end
   end

   assign above_rd  = above_rd_ff;
   assign centre_rd = centre_rd_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ids_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// laplacian, gain multiply, round and clamp over three stages
module ids_pipe (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire ids_pkg::stencil_type              in_data,
   input  wire ids_pkg::pix_type                  rt,
   input  wire logic [ids_pkg::GAIN_BITS-1:0]     gain,
   output logic                                   out_valid,
   output ids_pkg::result_type                    out_data,
   output ids_pkg::pipe_status_type               status
);

   logic                                 v1_ff, v2_ff, v3_ff;
   ids_pkg::stencil_type                 d1_ff;
   logic signed [ids_pkg::LAP_BITS-1:0]  lap2_ff;
   ids_pkg::pix_type                     u2_ff, u3_ff;
   logic                                 bypass2_ff, bypass3_ff;
   logic                                 last2_ff, last3_ff;
   logic signed [ids_pkg::PROD_BITS-1:0] prod3_ff;

   logic [ids_pkg::LAP_BITS-1:0]         sum1;
   logic [ids_pkg::LAP_BITS-1:0]         four_u1;
   logic signed [ids_pkg::LAP_BITS-1:0]  lap1;
   logic signed [ids_pkg::PROD_BITS-1:0] prod2;
   logic signed [ids_pkg::LAP_BITS-1:0]  delta3;
   logic signed [ids_pkg::RES_BITS-1:0]  res3;
   ids_pkg::pix_type                     clamp3;

   // stage 1: right neighbour arrives from the centre memory read register
   always_comb begin
      sum1 = {3'b000, d1_ff.up} + {3'b000, d1_ff.lf} + {3'b000, rt} + {3'b000, d1_ff.dn};
      four_u1 = {1'b0, d1_ff.u, 2'b00};
      lap1 = $signed(sum1 - four_u1);
   end

   // stage 2: kappa product with half-lsb rounding term
   always_comb begin
      prod2 = $signed({{(ids_pkg::PROD_BITS - ids_pkg::LAP_BITS){lap2_ff[ids_pkg::LAP_BITS-1]}},
                       lap2_ff})
              * $signed({{(ids_pkg::PROD_BITS - ids_pkg::GAIN_BITS){1'b0}}, gain})
              + $signed({{(ids_pkg::PROD_BITS - ids_pkg::GAIN_FRAC){1'b0}},
                         1'b1, {(ids_pkg::GAIN_FRAC - 1){1'b0}}});
   end

   // stage 3: floor shift, add to centre, clamp
   always_comb begin
      delta3 = prod3_ff[ids_pkg::GAIN_FRAC +: ids_pkg::LAP_BITS];
      res3 = $signed({{(ids_pkg::RES_BITS - ids_pkg::PIX_BITS){1'b0}}, u3_ff})
             + $signed({delta3[ids_pkg::LAP_BITS-1], delta3});
      if (res3[ids_pkg::RES_BITS-1]) begin
         clamp3 = '0;
      end else if (res3[ids_pkg::RES_BITS-2:ids_pkg::PIX_BITS] != '0) begin
         clamp3 = '1;
      end else begin
         clamp3 = res3[ids_pkg::PIX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff      <= in_data;
      lap2_ff    <= lap1;
      u2_ff      <= d1_ff.u;
      bypass2_ff <= d1_ff.bypass;
      last2_ff   <= d1_ff.last;
      prod3_ff   <= prod2;
      u3_ff      <= u2_ff;
      bypass3_ff <= bypass2_ff;
      last3_ff   <= last2_ff;
   end

   assign out_valid      = v3_ff;
   assign out_data.pixel = bypass3_ff ? u3_ff : clamp3;
   assign out_data.last  = last3_ff;
   assign status.v1      = v1_ff;
   assign status.v2      = v2_ff;
   assign status.v3      = v3_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ids_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result queue that drives the response channel
module ids_outq (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   input  wire ids_pkg::result_type                   push_data,
   output logic [ids_pkg::OUTQ_CNT_BITS-1:0]          count,
   ids_rsp_if.source                                  rsp_ch
);

   ids_pkg::result_type                  slot_ff [ids_pkg::OUTQ_DEPTH];
   logic [ids_pkg::OUTQ_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ids_pkg::OUTQ_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ids_pkg::OUTQ_CNT_BITS-1:0]    count_ff, count_in;
   logic                                 pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_ch.valid      = (count_ff != '0);
   assign rsp_ch.pixel_out  = slot_ff[rd_ptr_ff].pixel;
   assign rsp_ch.frame_last = slot_ff[rd_ptr_ff].last;
   assign count             = count_ff;

endmodule
`default_nettype wire
